@@ rtl/core/ihs_pkg.sv @@
// Shared types, constants and arithmetic helpers for the implicit heat step unit.
`default_nettype none
package ihs_pkg;

  localparam int MAX_CELLS  = 64;
  localparam int ADDR_W     = $clog2(MAX_CELLS);
  localparam int CNT_W      = $clog2(MAX_CELLS + 1);
  localparam int DIV_W      = 48;
  localparam int DIV_CNT_W  = $clog2(DIV_W);
  localparam int APB_AW     = 5;
  localparam int REG_W      = 3;
  localparam int CELLCNT_W  = 7;
  localparam int IN_W       = 8;
  localparam int OUT_W      = 104;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_STEP  = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [REG_W-1:0] {
    REG_COUPLING   = 3'd0,
    REG_DIAG_LEFT  = 3'd1,
    REG_DIAG_RIGHT = 3'd2,
    REG_RHS_LEFT   = 3'd3,
    REG_RHS_RIGHT  = 3'd4,
    REG_SRC_BASE   = 3'd5,
    REG_SRC_SLOPE  = 3'd6,
    REG_CELL_COUNT = 3'd7
  } reg_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_RD_REQ,
    ST_RD_DAT,
    ST_FWD_RD,
    ST_FWD_DIV,
    ST_FWD_MUL1,
    ST_FWD_MUL2,
    ST_FWD_WR,
    ST_LAST,
    ST_BK_DIV,
    ST_BK_SQ,
    ST_BK_ACC,
    ST_BK_RD,
    ST_BK_MUL,
    ST_BK_NUM,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    MUL_M_CPL,
    MUL_M_RPREV,
    MUL_CPL_NEWT,
    MUL_SQUARE
  } mul_sel_e;

  typedef enum logic [1:0] {
    DIV_CPL_PPREV,
    DIV_RPREV_PPREV,
    DIV_NUM_PIV
  } div_sel_e;

  typedef struct packed {
    logic     accept;
    logic     clr_temp;
    logic     t_rd;
    logic     t_wr;
    logic     st_rd;
    logic     fwd_wr;
    logic     i_inc;
    logic     i_dec;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     prod_a_en;
    logic     div_start;
    div_sel_e div_sel;
    logic     acc_en;
    logic     res_read;
    logic     set_fail;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] in_op;
    logic       i_zero;
    logic       i_last;
    logic       p_prev_zero;
    logic       div_done;
    logic       out_free;
    logic       fail;
  } sts_t;

  function automatic logic signed [63:0] sx64(input logic [31:0] v);
    sx64 = {{32{v[31]}}, v};
  endfunction

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      sat32 = 32'h7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      sat32 = 32'h8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  // product / 2^16, truncated toward zero
  function automatic logic signed [49:0] qshift(input logic signed [65:0] p);
    logic signed [65:0] t;
    t = p + (p[65] ? 66'sd65535 : 66'sd0);
    qshift = t[65:16];
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/implicit_heat_step_tridiagonal_unit.sv @@
// Top level of the implicit heat step unit: controller plus datapath.
//
// Solves one implicit heat step on a grid of up to 64 cells (Thomas algorithm, signed
// Q16.16) and also clears or reads the grid; one item in, one result out. An item is
// taken only when the unit is idle. A step stops early on a zero pivot. Each cell but
// the first costs two runs of the shared bit-serial divider, one in the forward sweep
// and one in back substitution, plus multiplies and store accesses. A finished result
// sits in an output register, so the next item may be taken before it is read.
`default_nettype none
module implicit_heat_step_tridiagonal_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [ihs_pkg::IN_W-1:0]        s_axis_tdata,   // [1:0] operation, [7:2] cell_index
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [ihs_pkg::OUT_W-1:0]            m_axis_tdata,   // [31:0] temperature,
                                                               // [95:32] change_sq_sum,
                                                               // [96] status, rest zero
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [ihs_pkg::APB_AW-1:0]      paddr,
  input  wire logic [31:0]                     pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  ihs_pkg::cmd_t cmd;
  ihs_pkg::sts_t sts;

  assign pready = 1'b1;

  ihs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ihs_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
`default_nettype wire

@@ rtl/core/ihs_div.sv @@
// Bit-serial signed Q16.16 divider with saturation, one quotient bit a cycle.
`default_nettype none
module ihs_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output logic             done_o,
  output logic [31:0]      q_o
);

  logic                               busy_q, busy_d;
  logic                               done_q, done_d;
  logic [ihs_pkg::DIV_CNT_W-1:0]      cnt_q, cnt_d;
  logic                               neg_q, neg_d;
  logic [32:0]                        rem_q, rem_d;
  logic [ihs_pkg::DIV_W-1:0]          dvd_q, dvd_d;
  logic [31:0]                        dvs_q, dvs_d;
  logic [31:0]                        mag_a, mag_b;
  logic [32:0]                        rem_sh;
  logic                               fits;

  assign mag_a = a_i[31] ? (~a_i + 32'd1) : a_i;
  assign mag_b = b_i[31] ? (~b_i + 32'd1) : b_i;
  assign rem_sh = {rem_q[31:0], dvd_q[ihs_pkg::DIV_W-1]};
  assign fits = (rem_sh >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = '0;
      neg_d  = a_i[31] ^ b_i[31];
      rem_d  = '0;
      dvd_d  = {mag_a, 16'h0000};
      dvs_d  = mag_b;
    end else if (busy_q) begin
      rem_d = fits ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
      dvd_d = {dvd_q[ihs_pkg::DIV_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == ihs_pkg::DIV_CNT_W'(ihs_pkg::DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
  end

  always_comb begin
    if (neg_q) begin
      if (dvd_q > ihs_pkg::DIV_W'(64'h8000_0000)) begin
        q_o = 32'h8000_0000;
      end else begin
        q_o = ~dvd_q[31:0] + 32'd1;
      end
    end else begin
      if (dvd_q > ihs_pkg::DIV_W'(64'h7FFF_FFFF)) begin
        q_o = 32'h7FFF_FFFF;
      end else begin
        q_o = dvd_q[31:0];
      end
    end
  end

  assign done_o = done_q;

endmodule
`default_nettype wire

@@ rtl/core/ihs_ctrl.sv @@
// Sequencer for clear, read and the forward/back sweeps of one time step.
`default_nettype none
module ihs_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire ihs_pkg::sts_t sts_i,
  output ihs_pkg::cmd_t      cmd_o
);

  ihs_pkg::state_e state_q, state_d;
  logic            finish;

  // finish: result may go to the output register
  assign finish = sts_i.out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ihs_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          case (sts_i.in_op)
            ihs_pkg::OP_CLEAR: state_d = ihs_pkg::ST_CLEAR;
            ihs_pkg::OP_STEP:  state_d = ihs_pkg::ST_FWD_RD;
            ihs_pkg::OP_READ:  state_d = ihs_pkg::ST_RD_REQ;
            default:           state_d = ihs_pkg::ST_DONE;
          endcase
        end
      end
      ihs_pkg::ST_CLEAR:  state_d = ihs_pkg::ST_DONE;
      ihs_pkg::ST_RD_REQ: state_d = ihs_pkg::ST_RD_DAT;
      ihs_pkg::ST_RD_DAT: state_d = ihs_pkg::ST_DONE;
      ihs_pkg::ST_FWD_RD: begin
        if (sts_i.i_zero) begin
          state_d = ihs_pkg::ST_FWD_WR;
        end else if (sts_i.p_prev_zero) begin
          state_d = ihs_pkg::ST_DONE;
        end else begin
          state_d = ihs_pkg::ST_FWD_DIV;
        end
      end
      ihs_pkg::ST_FWD_DIV:  if (sts_i.div_done) state_d = ihs_pkg::ST_FWD_MUL1;
      ihs_pkg::ST_FWD_MUL1: state_d = ihs_pkg::ST_FWD_MUL2;
      ihs_pkg::ST_FWD_MUL2: state_d = ihs_pkg::ST_FWD_WR;
      ihs_pkg::ST_FWD_WR: begin
        state_d = sts_i.i_last ? ihs_pkg::ST_LAST : ihs_pkg::ST_FWD_RD;
      end
      ihs_pkg::ST_LAST: begin
        state_d = sts_i.p_prev_zero ? ihs_pkg::ST_DONE : ihs_pkg::ST_BK_DIV;
      end
      ihs_pkg::ST_BK_DIV: if (sts_i.div_done) state_d = ihs_pkg::ST_BK_SQ;
      ihs_pkg::ST_BK_SQ:  state_d = ihs_pkg::ST_BK_ACC;
      ihs_pkg::ST_BK_ACC: begin
        state_d = sts_i.i_zero ? ihs_pkg::ST_DONE : ihs_pkg::ST_BK_RD;
      end
      ihs_pkg::ST_BK_RD:  state_d = ihs_pkg::ST_BK_MUL;
      ihs_pkg::ST_BK_MUL: state_d = ihs_pkg::ST_BK_NUM;
      ihs_pkg::ST_BK_NUM: state_d = ihs_pkg::ST_BK_DIV;
      // common wrap-up: wait for the output slot
      ihs_pkg::ST_DONE:   if (finish) state_d = ihs_pkg::ST_IDLE;
      default:            state_d = ihs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = ihs_pkg::MUL_M_CPL;
    cmd_o.div_sel = ihs_pkg::DIV_CPL_PPREV;
    in_ready_o    = 1'b0;
    case (state_q)
      ihs_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ihs_pkg::ST_CLEAR:  cmd_o.clr_temp = 1'b1;
      ihs_pkg::ST_RD_REQ: cmd_o.t_rd = 1'b1;
      ihs_pkg::ST_RD_DAT: cmd_o.res_read = 1'b1;
      ihs_pkg::ST_FWD_RD: begin
        cmd_o.t_rd = 1'b1;
        if (!sts_i.i_zero) begin
          if (sts_i.p_prev_zero) begin
            cmd_o.set_fail = 1'b1;
          end else begin
            cmd_o.div_start = 1'b1;
            cmd_o.div_sel   = ihs_pkg::DIV_CPL_PPREV;
          end
        end
      end
      ihs_pkg::ST_FWD_MUL1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = ihs_pkg::MUL_M_CPL;
      end
      ihs_pkg::ST_FWD_MUL2: begin
        cmd_o.mul_en    = 1'b1;
        cmd_o.mul_sel   = ihs_pkg::MUL_M_RPREV;
        cmd_o.prod_a_en = 1'b1;
      end
      ihs_pkg::ST_FWD_WR: begin
        cmd_o.fwd_wr = 1'b1;
        cmd_o.i_inc  = !sts_i.i_last;
      end
      ihs_pkg::ST_LAST: begin
        if (sts_i.p_prev_zero) begin
          cmd_o.set_fail = 1'b1;
        end else begin
          cmd_o.t_rd      = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = ihs_pkg::DIV_RPREV_PPREV;
        end
      end
      ihs_pkg::ST_BK_SQ: begin
        cmd_o.t_wr    = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = ihs_pkg::MUL_SQUARE;
      end
      ihs_pkg::ST_BK_ACC: begin
        cmd_o.acc_en = !sts_i.fail;
        cmd_o.i_dec  = !sts_i.i_zero;
      end
      ihs_pkg::ST_BK_RD: begin
        cmd_o.t_rd  = 1'b1;
        cmd_o.st_rd = 1'b1;
      end
      ihs_pkg::ST_BK_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = ihs_pkg::MUL_CPL_NEWT;
      end
      ihs_pkg::ST_BK_NUM: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = ihs_pkg::DIV_NUM_PIV;
      end
      ihs_pkg::ST_DONE: begin
        cmd_o.out_load = finish;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ihs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/ihs_dp.sv @@
// Datapath: registers, cell stores, multiplier, divider, accumulator, output register.
`default_nettype none
module ihs_dp (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ihs_pkg::APB_AW-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  input  wire logic [ihs_pkg::IN_W-1:0]    in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [ihs_pkg::OUT_W-1:0]        out_data_o,
  input  wire ihs_pkg::cmd_t               cmd_i,
  output ihs_pkg::sts_t                    sts_o
);

  localparam int CW = ihs_pkg::CELLCNT_W;
  localparam int AW = ihs_pkg::ADDR_W;
  localparam int NW = ihs_pkg::CNT_W;

  // configuration
  logic [31:0]   cpl_q, dl_q, dr_q, rl_q, rr_q, sb_q, ss_q;
  logic [CW-1:0] cc_q;
  logic          cfg_wr;
  logic [ihs_pkg::REG_W-1:0] reg_idx;

  assign cfg_wr  = psel & penable & pwrite;
  assign reg_idx = paddr[ihs_pkg::APB_AW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpl_q <= 32'h0000_0000;
      dl_q  <= 32'h0001_0000;
      dr_q  <= 32'h0001_0000;
      rl_q  <= 32'h0000_0000;
      rr_q  <= 32'h0000_0000;
      sb_q  <= 32'h0000_0000;
      ss_q  <= 32'h0000_0000;
      cc_q  <= CW'(ihs_pkg::MAX_CELLS);
    end else if (cfg_wr) begin
      case (reg_idx)
        ihs_pkg::REG_COUPLING:   cpl_q <= pwdata;
        ihs_pkg::REG_DIAG_LEFT:  dl_q  <= pwdata;
        ihs_pkg::REG_DIAG_RIGHT: dr_q  <= pwdata;
        ihs_pkg::REG_RHS_LEFT:   rl_q  <= pwdata;
        ihs_pkg::REG_RHS_RIGHT:  rr_q  <= pwdata;
        ihs_pkg::REG_SRC_BASE:   sb_q  <= pwdata;
        ihs_pkg::REG_SRC_SLOPE:  ss_q  <= pwdata;
        ihs_pkg::REG_CELL_COUNT: cc_q  <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      ihs_pkg::REG_COUPLING:   prdata = cpl_q;
      ihs_pkg::REG_DIAG_LEFT:  prdata = dl_q;
      ihs_pkg::REG_DIAG_RIGHT: prdata = dr_q;
      ihs_pkg::REG_RHS_LEFT:   prdata = rl_q;
      ihs_pkg::REG_RHS_RIGHT:  prdata = rr_q;
      ihs_pkg::REG_SRC_BASE:   prdata = sb_q;
      ihs_pkg::REG_SRC_SLOPE:  prdata = ss_q;
      ihs_pkg::REG_CELL_COUNT: prdata = {{(32-CW){1'b0}}, cc_q};
      default:                 prdata = 32'h0;
    endcase
  end

  // item latch and cell index
  logic [1:0]    op_q;
  logic [5:0]    idx_q;
  logic [NW-1:0] n_q, n_d;
  logic [AW-1:0] i_q;
  logic          fail_q;

  always_comb begin
    if (cc_q < CW'(2)) begin
      n_d = NW'(2);
    end else if (32'(cc_q) > ihs_pkg::MAX_CELLS) begin
      n_d = NW'(ihs_pkg::MAX_CELLS);
    end else begin
      n_d = NW'(cc_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q  <= in_data_i[1:0];
      idx_q <= in_data_i[7:2];
      n_q   <= n_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q    <= '0;
      fail_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        i_q    <= '0;
        fail_q <= 1'b0;
      end else if (cmd_i.i_inc) begin
        i_q <= i_q + 1'b1;
      end else if (cmd_i.i_dec) begin
        i_q <= i_q - 1'b1;
      end
      if (cmd_i.set_fail) fail_q <= 1'b1;
    end
  end

  logic i_zero, i_last;
  assign i_zero = (i_q == '0);
  assign i_last = (NW'(i_q) == n_q - NW'(1));

  // temperature store: memory plus per-entry valid bits (reset reads as zero)
  logic [31:0]                    temp_mem [ihs_pkg::MAX_CELLS];
  logic [ihs_pkg::MAX_CELLS-1:0]  tv_q;
  logic [AW-1:0]                  t_addr;
  logic [31:0]                    t_rd_q;
  logic                           tv_rd_q;
  logic [31:0]                    t_val;
  logic [31:0]                    div_q;

  assign t_addr = (op_q == ihs_pkg::OP_READ) ? AW'(idx_q) : i_q;
  assign t_val  = tv_rd_q ? t_rd_q : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tv_q <= '0;
    end else if (cmd_i.clr_temp) begin
      tv_q <= '0;
    end else if (cmd_i.t_wr) begin
      tv_q[i_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.t_rd) begin
      t_rd_q  <= temp_mem[t_addr];
      tv_rd_q <= tv_q[t_addr];
    end
    if (cmd_i.t_wr) temp_mem[i_q] <= div_q;
  end

  // eliminated pivots and right-hand sides
  logic [31:0] piv_mem [ihs_pkg::MAX_CELLS];
  logic [31:0] rhs_mem [ihs_pkg::MAX_CELLS];
  logic [31:0] piv_rd_q, rhs_rd_q;
  logic [31:0] piv_new, rhs_new;
  logic [31:0] p_prev_q, r_prev_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.fwd_wr) begin
      piv_mem[i_q] <= piv_new;
      rhs_mem[i_q] <= rhs_new;
      p_prev_q     <= piv_new;
      r_prev_q     <= rhs_new;
    end
    if (cmd_i.st_rd) begin
      piv_rd_q <= piv_mem[i_q];
      rhs_rd_q <= rhs_mem[i_q];
    end
  end

  // multiplier, one product per cycle, registered
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_q;
  logic signed [49:0] prod_a_q;
  logic signed [49:0] mul_scaled;
  logic [31:0]        newt_q;
  logic signed [32:0] diff;
  logic [32:0]        abs_d;

  assign diff  = {div_q[31], div_q} - {t_val[31], t_val};
  assign abs_d = diff[32] ? (~diff + 33'd1) : diff;
  assign mul_scaled = ihs_pkg::qshift(mul_q);

  always_comb begin
    case (cmd_i.mul_sel)
      ihs_pkg::MUL_M_CPL: begin
        mul_a = {div_q[31], div_q};
        mul_b = {cpl_q[31], cpl_q};
      end
      ihs_pkg::MUL_M_RPREV: begin
        mul_a = {div_q[31], div_q};
        mul_b = {r_prev_q[31], r_prev_q};
      end
      ihs_pkg::MUL_CPL_NEWT: begin
        mul_a = {cpl_q[31], cpl_q};
        mul_b = {newt_q[31], newt_q};
      end
      default: begin
        mul_a = abs_d;
        mul_b = abs_d;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en)    mul_q    <= mul_a * mul_b;
    if (cmd_i.prod_a_en) prod_a_q <= mul_scaled;
    if (cmd_i.t_wr)      newt_q   <= div_q;
  end

  // forward elimination of one cell
  logic signed [47:0] slope_acc_q;
  logic signed [63:0] init_r, prod_a64, prod_b64;
  logic [31:0]        inner, init_p, r_sat;

  assign inner    = ihs_pkg::sat32(64'sd65536 - (ihs_pkg::sx64(cpl_q) <<< 1));
  assign init_p   = i_zero ? dl_q : (i_last ? dr_q : inner);
  assign prod_a64 = i_zero ? 64'sd0 : {{14{prod_a_q[49]}}, prod_a_q};
  assign prod_b64 = i_zero ? 64'sd0 : {{14{mul_scaled[49]}}, mul_scaled};
  assign init_r   = ihs_pkg::sx64(t_val) + ihs_pkg::sx64(sb_q)
                  + {{16{slope_acc_q[47]}}, slope_acc_q}
                  + (i_zero ? ihs_pkg::sx64(rl_q) : 64'sd0)
                  + (i_last ? ihs_pkg::sx64(rr_q) : 64'sd0);
  assign r_sat    = ihs_pkg::sat32(init_r);
  assign rhs_new  = ihs_pkg::sat32(ihs_pkg::sx64(r_sat) - prod_b64);
  assign piv_new  = ihs_pkg::sat32(ihs_pkg::sx64(init_p) - prod_a64);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      slope_acc_q <= '0;
    end else if (cmd_i.fwd_wr) begin
      slope_acc_q <= slope_acc_q + {{16{ss_q[31]}}, ss_q};
    end
  end

  // divider operand selection; back-substitution numerator
  logic [31:0] div_a, div_b, num;

  assign num = ihs_pkg::sat32(ihs_pkg::sx64(rhs_rd_q) - {{14{mul_scaled[49]}}, mul_scaled});

  always_comb begin
    case (cmd_i.div_sel)
      ihs_pkg::DIV_CPL_PPREV: begin
        div_a = cpl_q;
        div_b = p_prev_q;
      end
      ihs_pkg::DIV_RPREV_PPREV: begin
        div_a = r_prev_q;
        div_b = p_prev_q;
      end
      default: begin
        div_a = num;
        div_b = piv_rd_q;
      end
    endcase
  end

  logic div_done;

  ihs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .a_i     (div_a),
    .b_i     (div_b),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  // results
  logic [31:0] res_temp_q;
  logic [63:0] sum_q;
  logic [64:0] sum_add;
  logic        in_range;

  assign sum_add  = {1'b0, sum_q} + {1'b0, mul_q[63:0]};
  assign in_range = (32'(idx_q) < ihs_pkg::MAX_CELLS);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      res_temp_q <= 32'h0;
      sum_q      <= 64'h0;
    end else begin
      if (cmd_i.res_read) res_temp_q <= in_range ? t_val : 32'h0;
      if (cmd_i.acc_en)   sum_q <= sum_add[64] ? {64{1'b1}} : sum_add[63:0];
    end
  end

  // output register
  logic        out_valid_q;
  logic [31:0] out_temp_q;
  logic [63:0] out_sum_q;
  logic        out_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_temp_q   <= res_temp_q;
      out_sum_q    <= fail_q ? 64'h0 : sum_q;
      out_status_q <= fail_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {7'b0, out_status_q, out_sum_q, out_temp_q};

  assign sts_o.in_op       = cmd_i.accept ? in_data_i[1:0] : op_q;
  assign sts_o.i_zero      = i_zero;
  assign sts_o.i_last      = i_last;
  assign sts_o.p_prev_zero = (p_prev_q == 32'h0);
  assign sts_o.div_done    = div_done;
  assign sts_o.out_free    = !out_valid_q || out_ready_i;
  assign sts_o.fail        = fail_q;

endmodule
`default_nettype wire

@@ dv/tb.sv @@
// Self-checking testbench for the implicit heat step unit: stream stimulus, APB setup, own predictor.
`timescale 1ns / 1ps
module tb;

  localparam logic [1:0] OP_NONE = 2'd3;  // undefined operation, no effect
  localparam int unsigned LIMIT = 3000000;
  localparam int NPHASE = 12;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [ihs_pkg::IN_W-1:0] s_axis_tdata = '0;  // [1:0] operation, [7:2] cell_index
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [ihs_pkg::OUT_W-1:0] m_axis_tdata;  // [31:0] temperature, [95:32] change_sq_sum, [96] status
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ihs_pkg::APB_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  implicit_heat_step_tridiagonal_unit dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  typedef struct packed {
    logic [31:0] temp;
    logic [63:0] sq_sum;
    logic        status;
  } heat_res_t;

  // predictor copy of the grid and registers
  int          grid [ihs_pkg::MAX_CELLS];
  int          cpl, dl, dr, rl, rr, sb, ss;
  logic [6:0]  ncells;
  heat_res_t   pending[$];
  int          mode;
  int unsigned cycles, errors, results, n_steps, n_fails;

  function automatic int sat(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return int'(v);
  endfunction

  function automatic longint qm(int a, int b);
    return (longint'(a) * longint'(b)) / 65536;
  endfunction

  function automatic int qd(longint a, int b);
    return sat((a * 65536) / longint'(b));
  endfunction

  function automatic heat_res_t predict_heat(logic [1:0] op, logic [5:0] idx);
    heat_res_t r;
    int n, i, inner;
    int piv [ihs_pkg::MAX_CELLS];
    int rhs [ihs_pkg::MAX_CELLS];
    int nt [ihs_pkg::MAX_CELLS];
    longint acc, d;
    longint unsigned sum, sq;
    r = '0;
    case (op)
      ihs_pkg::OP_CLEAR: foreach (grid[k]) grid[k] = 0;
      ihs_pkg::OP_READ: r.temp = grid[idx];
      ihs_pkg::OP_STEP: begin
        n = ncells;
        if (n < 2) n = 2;
        if (n > ihs_pkg::MAX_CELLS) n = ihs_pkg::MAX_CELLS;
        inner = sat(64'sd65536 - 2 * longint'(cpl));
        for (i = 0; i < n; i++) begin
          acc = longint'(grid[i]) + sb + longint'(ss) * i;
          if (i == 0) acc += rl;
          if (i == n - 1) acc += rr;
          rhs[i] = sat(acc);
          piv[i] = (i == 0) ? dl : (i == n - 1) ? dr : inner;
        end
        r.status = 1'b0;
        for (i = 1; i < n && !r.status; i++) begin
          if (piv[i-1] == 0) r.status = 1'b1;
          else begin
            int m;
            m = qd(cpl, piv[i-1]);
            piv[i] = sat(longint'(piv[i]) - qm(m, cpl));
            rhs[i] = sat(longint'(rhs[i]) - qm(m, rhs[i-1]));
          end
        end
        if (!r.status && piv[n-1] == 0) r.status = 1'b1;
        if (!r.status) begin
          nt[n-1] = qd(rhs[n-1], piv[n-1]);
          for (i = n - 2; i >= 0; i--)
            nt[i] = qd(sat(longint'(rhs[i]) - qm(cpl, nt[i+1])), piv[i]);
          sum = 0;
          for (i = 0; i < n; i++) begin
            d = longint'(nt[i]) - longint'(grid[i]);
            if (d < 0) d = -d;
            sq = longint'(d) * longint'(d);
            sum = (sum > 64'hFFFF_FFFF_FFFF_FFFF - sq) ? 64'hFFFF_FFFF_FFFF_FFFF : sum + sq;
            grid[i] = nt[i];
          end
          r.sq_sum = sum;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic apb_write(ihs_pkg::reg_e idx, logic [31:0] val);
    @(negedge clk_i);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = ihs_pkg::APB_AW'(4 * int'(idx)); pwdata = val;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    case (idx)
      ihs_pkg::REG_COUPLING:   cpl = val;
      ihs_pkg::REG_DIAG_LEFT:  dl = val;
      ihs_pkg::REG_DIAG_RIGHT: dr = val;
      ihs_pkg::REG_RHS_LEFT:   rl = val;
      ihs_pkg::REG_RHS_RIGHT:  rr = val;
      ihs_pkg::REG_SRC_BASE:   sb = val;
      ihs_pkg::REG_SRC_SLOPE:  ss = val;
      ihs_pkg::REG_CELL_COUNT: ncells = val[6:0];
      default: ;
    endcase
  endtask

  // expected result pushed at the edge the item is taken
  task automatic send_item(logic [1:0] op, logic [5:0] idx, bit typed, heat_res_t want);
    heat_res_t got;
    int gap;
    gap = (mode == 1) ? 82 : (mode == 3) ? 28 : 0;
    while ($urandom_range(99) < gap) @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {idx, op};
    do @(posedge clk_i); while (!s_axis_tready);
    got = predict_heat(op, idx);
    pending.push_back(typed ? want : got);
    if (op == ihs_pkg::OP_STEP) n_steps++;
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic drain();
    while (pending.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    int stall;
    stall = (mode == 2) ? 82 : (mode == 3) ? 28 : 0;
    m_axis_tready = ($urandom_range(99) >= stall);
  end

  always @(posedge clk_i) begin
    heat_res_t exp_r, act;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      act = {m_axis_tdata[31:0], m_axis_tdata[95:32], m_axis_tdata[96]};
      results++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", act);
      end else begin
        exp_r = pending.pop_front();
        if (act.status) n_fails++;
        if (act.temp !== exp_r.temp || act.sq_sum !== exp_r.sq_sum
            || act.status !== exp_r.status) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: temp %h/%h sum %h/%h status %b/%b (exp/act)",
                     exp_r.temp, act.temp, exp_r.sq_sum, act.sq_sum,
                     exp_r.status, act.status);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("implicit_heat_step_tridiagonal_unit verification failed");
      $finish;
    end
  end

  typedef struct {
    logic [1:0] op;
    logic [5:0] idx;
    bit         typed;
    heat_res_t  want;
  } row_t;

  row_t dir_rows[] = '{
    '{ihs_pkg::OP_READ,  6'd0,  1'b1, '0},
    '{ihs_pkg::OP_READ,  6'd63, 1'b1, '0},
    '{OP_NONE,           6'd63, 1'b1, '0},
    '{ihs_pkg::OP_STEP,  6'd0,  1'b1, '0},   // reset setup: identity system, nothing moves
    '{ihs_pkg::OP_READ,  6'd42, 1'b1, '0},
    '{ihs_pkg::OP_READ,  6'd21, 1'b1, '0},
    '{ihs_pkg::OP_CLEAR, 6'd0,  1'b1, '0},
    '{OP_NONE,           6'd0,  1'b1, '0},
    '{ihs_pkg::OP_STEP,  6'd63, 1'b0, '0},
    '{ihs_pkg::OP_READ,  6'd1,  1'b0, '0}
  };

  initial begin
    logic [31:0] v [8];
    int items, pstep, r, p, k;
    foreach (grid[k2]) grid[k2] = 0;
    cpl = 0; dl = 65536; dr = 65536; rl = 0; rr = 0; sb = 0; ss = 0; ncells = 7'd64;
    mode = 0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    foreach (dir_rows[k2])
      send_item(dir_rows[k2].op, dir_rows[k2].idx, dir_rows[k2].typed, dir_rows[k2].want);
    for (p = 0; p < NPHASE; p++) begin
      drain();
      mode = p % 4;
      v[0] = $urandom_range(65536) - 32768;
      v[1] = $urandom_range(262144) - 65536;
      v[2] = $urandom_range(262144) - 65536;
      for (k = 3; k < 7; k++) v[k] = $urandom_range(1 << 22) - (1 << 21);
      v[7] = $urandom_range(2, 10);
      pstep = 30;
      case (p)
        1: begin v = '{default: 32'h7FFF_FFFF}; v[7] = 32'd0; end
        2: begin v = '{default: 32'h8000_0000}; v[7] = 32'd1; end
        3: v[1] = 32'd0;                     // zero pivot on the first cell
        4: begin v[7] = 32'd127; pstep = 8; end
        5: begin v[7] = 32'd64; pstep = 8; end
        6: v[2] = 32'd0;                     // zero diagonal on the last cell
        7: begin v[0] = $urandom; v[5] = $urandom; v[6] = $urandom; end
        default: ;
      endcase
      for (k = 0; k < 8; k++) apb_write(ihs_pkg::reg_e'(k), v[k]);
      for (items = 0; items < 82; items++) begin
        r = $urandom_range(99);
        if (r < pstep) send_item(ihs_pkg::OP_STEP, 6'($urandom), 1'b0, '0);
        else if (r < 80) send_item(ihs_pkg::OP_READ, 6'($urandom), 1'b0, '0);
        else if (r < 92) send_item(ihs_pkg::OP_CLEAR, 6'($urandom), 1'b0, '0);
        else send_item(OP_NONE, 6'($urandom), 1'b0, '0);
      end
    end
    drain();
    $display("ran %0d results over %0d register settings, %0d steps (%0d zero pivot)",
             results, NPHASE + 1, n_steps, n_fails);
    $display("mismatches: %0d, cycles: %0d", errors, cycles);
    if (errors == 0 && pending.size() == 0) begin
      $display("implicit_heat_step_tridiagonal_unit verification clean");
    end else begin
      $display("implicit_heat_step_tridiagonal_unit verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/ihs_pkg.sv
rtl/core/ihs_div.sv
rtl/core/ihs_ctrl.sv
rtl/core/ihs_dp.sv
rtl/core/implicit_heat_step_tridiagonal_unit.sv
dv/tb.sv
